// ===== rtl/core/sme_pkg.sv =====
`timescale 1ns / 1ps
package sme_pkg;

  localparam int unsigned StackDepth = 128;
  localparam int unsigned VarDepth   = 128;
  localparam int unsigned ProgDepth  = 256;
  localparam int unsigned SpW  = $clog2(StackDepth + 1);
  localparam int unsigned SaW  = $clog2(StackDepth);
  localparam int unsigned VaW  = $clog2(VarDepth);
  localparam int unsigned PcW  = $clog2(ProgDepth);

  typedef enum logic [3:0] {
    OP_PUSHA = 4'd0, OP_PUSHC = 4'd1, OP_BINOP = 4'd2, OP_NEG = 4'd3,
    OP_DEREF = 4'd4, OP_STORE = 4'd5, OP_JZ = 4'd6, OP_JMP = 4'd7,
    OP_WRITE = 4'd8, OP_DUP = 4'd9, OP_STOP = 4'd10
  } opcode_e;

  typedef enum logic [3:0] {
    BO_ADD = 4'd0, BO_SUB = 4'd1, BO_MUL = 4'd2, BO_DIV = 4'd3, BO_EQ = 4'd4,
    BO_NE = 4'd5, BO_LT = 4'd6, BO_GT = 4'd7, BO_LE = 4'd8, BO_GE = 4'd9
  } binop_e;

  typedef enum logic [2:0] {
    ST_OK = 3'd0, ST_HALT = 3'd1, ST_OVER = 3'd2, ST_UNDER = 3'd3,
    ST_DIVZ = 3'd4, ST_ADDR = 3'd5, ST_BAD = 3'd6
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE, S_RD1, S_RD2, S_WAIT, S_EXEC, S_ALU, S_VRD, S_VWAIT, S_FIN, S_CLR, S_OUT
  } state_e;

  // request to the shared ALU
  typedef struct packed {
    logic        start;
    binop_e      op;
    logic [31:0] a;
    logic [31:0] b;
  } alu_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] res;
  } alu_rsp_t;

endpackage

// ===== rtl/core/sme_alu.sv =====
`timescale 1ns / 1ps
module sme_alu import sme_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  alu_req_t req_i,
  output alu_rsp_t rsp_o
);

  logic [31:0] a_q, a_d, b_q, b_d, rem_q, rem_d, quo_q, quo_d, res_q, res_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d, neg_q, neg_d;
  logic [32:0] trial;
  logic [31:0] rsh;
  logic [31:0] prod;

  assign trial = {rem_q, a_q[31]} - {1'b0, b_q};
  assign prod  = req_i.a * req_i.b;

  always_comb begin
    a_d = a_q; b_d = b_q; rem_d = rem_q; quo_d = quo_q; res_d = res_q;
    cnt_d = cnt_q; busy_d = busy_q; done_d = 1'b0; neg_d = neg_q;
    rsh = 32'd0;
    if (req_i.start) begin
      done_d = 1'b1;
      case (req_i.op)
        BO_ADD: res_d = req_i.a + req_i.b;
        BO_SUB: res_d = req_i.a - req_i.b;
        BO_MUL: res_d = prod;
        BO_EQ:  res_d = {31'd0, req_i.a == req_i.b};
        BO_NE:  res_d = {31'd0, req_i.a != req_i.b};
        BO_LT:  res_d = {31'd0, $signed(req_i.a) <  $signed(req_i.b)};
        BO_GT:  res_d = {31'd0, $signed(req_i.a) >  $signed(req_i.b)};
        BO_LE:  res_d = {31'd0, $signed(req_i.a) <= $signed(req_i.b)};
        BO_GE:  res_d = {31'd0, $signed(req_i.a) >= $signed(req_i.b)};
        BO_DIV: begin
          // restoring division on magnitudes, one quotient bit a cycle
          done_d = 1'b0;
          busy_d = 1'b1;
          a_d    = req_i.a[31] ? (32'd0 - req_i.a) : req_i.a;
          b_d    = req_i.b[31] ? (32'd0 - req_i.b) : req_i.b;
          neg_d  = req_i.a[31] ^ req_i.b[31];
          rem_d  = 32'd0;
          quo_d  = 32'd0;
          cnt_d  = 6'd0;
        end
        default: res_d = 32'd0;
      endcase
    end else if (busy_q) begin
      a_d = {a_q[30:0], 1'b0};
      if (!trial[32]) begin
        rem_d = trial[31:0];
        quo_d = {quo_q[30:0], 1'b1};
      end else begin
        rem_d = {rem_q[30:0], a_q[31]};
        quo_d = {quo_q[30:0], 1'b0};
      end
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'd31) begin
        busy_d = 1'b0;
        done_d = 1'b1;
        rsh    = quo_d;
        res_d  = neg_q ? (32'd0 - rsh) : rsh;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 6'd0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d; b_q <= b_d; rem_q <= rem_d; quo_q <= quo_d;
    res_q <= res_d; neg_q <= neg_d;
  end

  assign rsp_o = '{done: done_q, res: res_q};

endmodule

// ===== rtl/core/sme_ram.sv =====
`timescale 1ns / 1ps
module sme_ram import sme_pkg::*; #(
  parameter int unsigned Depth = 128,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [31:0]      wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [31:0]      rdata_o
);

  logic [31:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== rtl/core/stack_machine_executor.sv =====
`timescale 1ns / 1ps
// Channel | dir | tdata fields (low bit up)                          | tuser
// s_axis  | in  | opcode[3:0], operand[35:4], pad to 40 bits         | -
// m_axis  | out | next_pc[7:0], write_value[39:8], status[42:40],
//         |     | stack_count[50:43], pad to 56 bits                  | write_valid
//
// Flow: an accepted item passes through S_RD1, S_RD2 and S_WAIT (stack reads)
// and S_EXEC, then its result shows in S_OUT, held there until its transfer,
// and the block goes back to idle. A binary operator adds a wait in S_ALU for
// the shared ALU, where a divide forms its 32 quotient bits one a cycle, and
// a dereference adds S_VRD, S_VWAIT and S_FIN. The stack and the variable
// memory are single-port-read RAMs with registered reads, which sets the
// per-item cost: up to two stack reads and one variable read.
// Reset: after reset a clearing pass writes zero to every variable word,
// during which s_axis_tready is low.
// Stalls: the result sits in an output register until taken; a new item is
// not accepted until then.
module stack_machine_executor import sme_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // opcode, operand
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // next_pc, write_value, status, stack_count
  output logic        m_axis_tuser    // write_valid
);

  state_e state_q, state_d;
  logic [3:0]     op_q, op_d;
  logic [31:0]    opd_q, opd_d;
  logic [SpW-1:0] sp_q, sp_d;
  logic [PcW-1:0] pc_q, pc_d, npc;
  logic           halt_q, halt_d;
  logic [31:0]    top_q, top_d, sec_q, sec_d;
  logic [VaW-1:0] clr_q, clr_d;
  // result register
  logic [PcW-1:0] rpc_q, rpc_d;
  logic           rwv_q, rwv_d;
  logic [31:0]    rwval_q, rwval_d;
  status_e        rst_q, rst_d;

  // stack RAM port
  logic           s_we;
  logic [SaW-1:0] s_wa, s_ra;
  logic [31:0]    s_wd, s_rd;
  // variable RAM port
  logic           v_we;
  logic [VaW-1:0] v_wa, v_ra;
  logic [31:0]    v_wd, v_rd;

  alu_req_t alu_req;
  alu_rsp_t alu_rsp;

  sme_ram #(.Depth(StackDepth)) u_stack (
    .clk_i, .we_i(s_we), .waddr_i(s_wa), .wdata_i(s_wd), .raddr_i(s_ra), .rdata_o(s_rd)
  );
  sme_ram #(.Depth(VarDepth)) u_vars (
    .clk_i, .we_i(v_we), .waddr_i(v_wa), .wdata_i(v_wd), .raddr_i(v_ra), .rdata_o(v_rd)
  );
  sme_alu u_alu (.clk_i, .rst_ni, .req_i(alu_req), .rsp_o(alu_rsp));

  assign npc = (32'(pc_q) + 32'd1 >= ProgDepth) ? '0 : PcW'(32'(pc_q) + 32'd1);

  function automatic logic tgt_ok(logic [31:0] t);
    return !t[31] && (t < ProgDepth);
  endfunction
  function automatic logic adr_ok(logic [31:0] a);
    return !a[31] && (a < VarDepth);
  endfunction

  logic [SaW-1:0] sp_m1, sp_m2, sp_lo;
  assign sp_lo = sp_q[SaW-1:0];
  assign sp_m1 = SaW'(sp_q - SpW'(1));
  assign sp_m2 = SaW'(sp_q - SpW'(2));

  always_comb begin
    state_d = state_q; op_d = op_q; opd_d = opd_q; sp_d = sp_q; pc_d = pc_q;
    halt_d = halt_q; top_d = top_q; sec_d = sec_q; clr_d = clr_q;
    rpc_d = rpc_q; rwv_d = rwv_q; rwval_d = rwval_q; rst_d = rst_q;
    s_we = 1'b0; s_wa = sp_m1; s_wd = top_q; s_ra = sp_m1;
    v_we = 1'b0; v_wa = clr_q; v_wd = 32'd0; v_ra = top_q[VaW-1:0];
    alu_req = '{start: 1'b0, op: binop_e'(opd_q[3:0]), a: sec_q, b: top_q};
    s_axis_tready = 1'b0;
    case (state_q)
      S_CLR: begin
        v_we = 1'b1;
        clr_d = clr_q + VaW'(1);
        if (32'(clr_q) == VarDepth - 1) state_d = S_IDLE;
      end
      S_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          op_d  = s_axis_tdata[3:0];
          opd_d = s_axis_tdata[35:4];
          state_d = S_RD1;
        end
      end
      S_RD1: begin
        s_ra = sp_m1; state_d = S_RD2;
      end
      S_RD2: begin
        s_ra = sp_m2; top_d = s_rd; state_d = S_WAIT;
      end
      S_WAIT: begin
        sec_d = s_rd; state_d = S_EXEC;
      end
      S_EXEC: begin
        rpc_d = pc_q; rwv_d = 1'b0; rwval_d = 32'd0; rst_d = ST_OK;
        state_d = S_OUT;
        if (halt_q) rst_d = ST_HALT;
        else begin
          case (op_q)
            OP_PUSHA, OP_PUSHC: begin
              if (32'(sp_q) >= StackDepth) rst_d = ST_OVER;
              else begin
                s_we = 1'b1; s_wa = sp_lo; s_wd = opd_q;
                sp_d = sp_q + SpW'(1); pc_d = npc; rpc_d = npc;
              end
            end
            OP_BINOP: begin
              if (opd_q > 32'd9) rst_d = ST_BAD;
              else if (sp_q < SpW'(2)) rst_d = ST_UNDER;
              else if (opd_q[3:0] == BO_DIV && top_q == 32'd0) rst_d = ST_DIVZ;
              else begin
                alu_req.start = 1'b1; state_d = S_ALU;
              end
            end
            OP_NEG: begin
              if (sp_q < SpW'(1)) rst_d = ST_UNDER;
              else begin
                s_we = 1'b1; s_wa = sp_m1; s_wd = 32'd0 - top_q;
                pc_d = npc; rpc_d = npc;
              end
            end
            OP_DEREF: begin
              if (sp_q < SpW'(1)) rst_d = ST_UNDER;
              else if (!adr_ok(top_q)) rst_d = ST_ADDR;
              else state_d = S_VRD;
            end
            OP_STORE: begin
              if (sp_q < SpW'(2)) rst_d = ST_UNDER;
              else if (!adr_ok(sec_q)) rst_d = ST_ADDR;
              else begin
                v_we = 1'b1; v_wa = sec_q[VaW-1:0]; v_wd = top_q;
                sp_d = sp_q - SpW'(2); pc_d = npc; rpc_d = npc;
              end
            end
            OP_JZ: begin
              if (!tgt_ok(opd_q)) rst_d = ST_BAD;
              else if (sp_q < SpW'(1)) rst_d = ST_UNDER;
              else begin
                sp_d = sp_q - SpW'(1);
                pc_d = (top_q == 32'd0) ? opd_q[PcW-1:0] : npc;
                rpc_d = pc_d;
              end
            end
            OP_JMP: begin
              if (!tgt_ok(opd_q)) rst_d = ST_BAD;
              else begin
                pc_d = opd_q[PcW-1:0]; rpc_d = pc_d;
              end
            end
            OP_WRITE: begin
              if (sp_q < SpW'(1)) rst_d = ST_UNDER;
              else begin
                rwv_d = 1'b1; rwval_d = top_q;
                sp_d = sp_q - SpW'(1); pc_d = npc; rpc_d = npc;
              end
            end
            OP_DUP: begin
              if (sp_q < SpW'(1)) rst_d = ST_UNDER;
              else if (32'(sp_q) >= StackDepth) rst_d = ST_OVER;
              else begin
                s_we = 1'b1; s_wa = sp_lo; s_wd = top_q;
                sp_d = sp_q + SpW'(1); pc_d = npc; rpc_d = npc;
              end
            end
            OP_STOP: begin
              halt_d = 1'b1; rst_d = ST_HALT;
            end
            default: rst_d = ST_BAD;
          endcase
        end
      end
      S_ALU: begin
        if (alu_rsp.done) begin
          s_we = 1'b1; s_wa = sp_m2; s_wd = alu_rsp.res;
          sp_d = sp_q - SpW'(1); pc_d = npc; rpc_d = npc;
          state_d = S_OUT;
        end
      end
      S_VRD: begin
        v_ra = top_q[VaW-1:0]; state_d = S_VWAIT;
      end
      S_VWAIT: begin
        state_d = S_FIN;
      end
      S_FIN: begin
        s_we = 1'b1; s_wa = sp_m1; s_wd = v_rd;
        pc_d = npc; rpc_d = npc; state_d = S_OUT;
      end
      S_OUT: begin
        if (m_axis_tready) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      sp_q <= '0; pc_q <= '0; halt_q <= 1'b0; clr_q <= '0;
    end else begin
      state_q <= state_d;
      sp_q <= sp_d; pc_q <= pc_d; halt_q <= halt_d; clr_q <= clr_d;
    end
  end

  // hold payload
  always_ff @(posedge clk_i) begin
    op_q <= op_d; opd_q <= opd_d; top_q <= top_d; sec_q <= sec_d;
    rpc_q <= rpc_d; rwv_q <= rwv_d; rwval_q <= rwval_d; rst_q <= rst_d;
  end

  assign m_axis_tvalid = (state_q == S_OUT);
  assign m_axis_tuser  = rwv_q;
  assign m_axis_tdata  = {5'd0, 8'(sp_q), rst_q, rwval_q, 8'(rpc_q)};

endmodule

// ===== rtl/core/sme_checker.sv =====
`timescale 1ns / 1ps
module sme_checker import sme_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [55:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  // never ready for input while a result is pending
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid)) else $error("ready while result pending");

  // a result follows an accepted item, never in the next cycle
  a_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !m_axis_tvalid) else $error("result too soon");

  // write_valid only with ok status
  a_wv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[42:40] == ST_OK))
    else $error("write with error status");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("result dropped");

endmodule

bind stack_machine_executor sme_checker u_sme_checker (
  .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready,
  .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
);

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
  import sme_pkg::*;

  localparam int unsigned NumItems = 1050;

  typedef struct packed {
    logic [7:0]  next_pc;
    logic        wr_valid;
    logic [31:0] wr_value;
    status_e     status;
    logic [7:0]  depth;
  } step_res_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;    // opcode, operand, pad
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;         // next_pc, write_value, status, stack_count, pad
  logic        m_axis_tuser;         // write_valid

  stack_machine_executor DUT (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

  always #2 clk_i = ~clk_i;

  // Two copies of the machine: index 0 follows accepted transfers, index 1
  // runs ahead at generation time so stimulus can be shaped by stack depth.
  logic [31:0] stk  [2][StackDepth];
  logic [31:0] vmem [2][VarDepth];
  int unsigned sp   [2];
  logic [7:0]  pc   [2];
  bit          halted [2];

  logic [39:0] pending_items[$];
  step_res_t   due_results[$];
  int          phase = 0;       // 0 none, 1 sender idle, 2 receiver stall, 3 both
  bit          took = 1'b0;
  int          n_gen = 0, n_acc = 0, n_res = 0, n_err = 0;
  int          status_seen[8];

  // Execute one instruction on machine m and return what the block answers.
  function automatic step_res_t exec_instr(input int m, input logic [3:0] op,
                                           input logic [31:0] opd);
    step_res_t   r;
    logic [7:0]  npc;
    logic [31:0] lhs, rhs, val;
    status_e     st;
    npc = pc[m] + 8'd1;
    st = ST_OK;
    r = '0;
    if (halted[m]) begin
      st = ST_HALT;
    end else begin
      case (opcode_e'(op))
        OP_PUSHA, OP_PUSHC: begin
          if (sp[m] >= StackDepth) st = ST_OVER;
          else begin
            stk[m][sp[m]] = opd;
            sp[m]++;
            pc[m] = npc;
          end
        end
        OP_BINOP: begin
          if (opd > 32'd9) st = ST_BAD;
          else if (sp[m] < 2) st = ST_UNDER;
          else begin
            rhs = stk[m][sp[m]-1];
            lhs = stk[m][sp[m]-2];
            val = '0;
            case (binop_e'(opd[3:0]))
              BO_ADD: val = lhs + rhs;
              BO_SUB: val = lhs - rhs;
              BO_MUL: val = lhs * rhs;
              BO_DIV: begin
                if (rhs == 0) st = ST_DIVZ;
                // most negative over minus one wraps to itself
                else if (lhs == 32'h8000_0000 && rhs == 32'hFFFF_FFFF) val = lhs;
                else val = $signed(lhs) / $signed(rhs);
              end
              BO_EQ: val = {31'd0, $signed(lhs) == $signed(rhs)};
              BO_NE: val = {31'd0, $signed(lhs) != $signed(rhs)};
              BO_LT: val = {31'd0, $signed(lhs) <  $signed(rhs)};
              BO_GT: val = {31'd0, $signed(lhs) >  $signed(rhs)};
              BO_LE: val = {31'd0, $signed(lhs) <= $signed(rhs)};
              default: val = {31'd0, $signed(lhs) >= $signed(rhs)};
            endcase
            if (st == ST_OK) begin
              stk[m][sp[m]-2] = val;
              sp[m]--;
              pc[m] = npc;
            end
          end
        end
        OP_NEG: begin
          if (sp[m] < 1) st = ST_UNDER;
          else begin
            stk[m][sp[m]-1] = 32'd0 - stk[m][sp[m]-1];
            pc[m] = npc;
          end
        end
        OP_DEREF: begin
          if (sp[m] < 1) st = ST_UNDER;
          else if (stk[m][sp[m]-1] >= VarDepth) st = ST_ADDR;
          else begin
            stk[m][sp[m]-1] = vmem[m][stk[m][sp[m]-1]];
            pc[m] = npc;
          end
        end
        OP_STORE: begin
          if (sp[m] < 2) st = ST_UNDER;
          else if (stk[m][sp[m]-2] >= VarDepth) st = ST_ADDR;
          else begin
            vmem[m][stk[m][sp[m]-2]] = stk[m][sp[m]-1];
            sp[m] -= 2;
            pc[m] = npc;
          end
        end
        OP_JZ: begin
          if (opd >= ProgDepth) st = ST_BAD;
          else if (sp[m] < 1) st = ST_UNDER;
          else begin
            sp[m]--;
            pc[m] = (stk[m][sp[m]] == 0) ? opd[7:0] : npc;
          end
        end
        OP_JMP: begin
          if (opd >= ProgDepth) st = ST_BAD;
          else pc[m] = opd[7:0];
        end
        OP_WRITE: begin
          if (sp[m] < 1) st = ST_UNDER;
          else begin
            r.wr_valid = 1'b1;
            r.wr_value = stk[m][sp[m]-1];
            sp[m]--;
            pc[m] = npc;
          end
        end
        OP_DUP: begin
          if (sp[m] < 1) st = ST_UNDER;
          else if (sp[m] >= StackDepth) st = ST_OVER;
          else begin
            stk[m][sp[m]] = stk[m][sp[m]-1];
            sp[m]++;
            pc[m] = npc;
          end
        end
        OP_STOP: begin
          halted[m] = 1'b1;
          st = ST_HALT;
        end
        default: st = ST_BAD;
      endcase
    end
    r.next_pc = pc[m];
    r.status  = st;
    r.depth   = sp[m][7:0];
    return r;
  endfunction

  // Queue one instruction and advance the look-ahead machine.
  task automatic add_instr(input logic [3:0] op, input logic [31:0] opd);
    pending_items.push_back({4'd0, opd, op});
    void'(exec_instr(1, op, opd));
    n_gen++;
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'd0;
      1: return 32'd1;
      2: return 32'hFFFF_FFFF;
      3: return 32'h8000_0000;
      4: return 32'h7FFF_FFFF;
      5: return $urandom_range(0, 300);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_addr();
    return ($urandom_range(0, 9) == 0) ? pick_value() : $urandom_range(0, VarDepth - 1);
  endfunction

  function automatic logic [31:0] pick_target();
    return ($urandom_range(0, 9) == 0) ? pick_value() : $urandom_range(0, ProgDepth - 1);
  endfunction

  // One short well-formed sequence with random content, or noise.
  task automatic gen_sequence();
    logic [3:0] op;
    case ($urandom_range(0, 99)) inside
      [0:7]: begin
        op = 4'($urandom_range(0, 15));
        if (op == OP_STOP) op = 4'd15;  // hold stop back for the tail
        add_instr(op, $urandom);
      end
      [8:22]: begin
        add_instr(OP_PUSHA, pick_addr());
        add_instr(OP_PUSHC, pick_value());
        add_instr(OP_STORE, 32'd0);
      end
      [23:35]: begin
        add_instr(OP_PUSHA, pick_addr());
        add_instr(OP_DEREF, 32'd0);
        add_instr(OP_WRITE, 32'd0);
      end
      [36:60]: begin
        add_instr(OP_PUSHC, pick_value());
        add_instr(OP_PUSHC, pick_value());
        add_instr(OP_BINOP, ($urandom_range(0, 15) == 0) ? $urandom : $urandom_range(0, 9));
        if ($urandom_range(0, 1)) add_instr(OP_WRITE, 32'd0);
      end
      [61:70]: begin
        add_instr(OP_NEG, 32'd0);
        add_instr(OP_DUP, 32'd0);
        add_instr(OP_WRITE, 32'd0);
      end
      [71:82]: begin
        add_instr(OP_PUSHC, $urandom_range(0, 1) ? 32'd0 : pick_value());
        add_instr(OP_JZ, pick_target());
      end
      [83:89]: add_instr(OP_JMP, pick_target());
      [90:92]: begin
        // fill to the top, then push and duplicate into overflow
        while (sp[1] < StackDepth) add_instr(OP_PUSHC, pick_value());
        add_instr(OP_PUSHA, pick_value());
        add_instr(OP_DUP, 32'd0);
      end
      default: begin
        // drain to empty, then hit every underflow path
        while (sp[1] > 0) add_instr(OP_WRITE, 32'd0);
        add_instr(OP_WRITE, 32'd0);
        add_instr(OP_NEG, 32'd0);
        add_instr(OP_DEREF, 32'd0);
        add_instr(OP_DUP, 32'd0);
        add_instr(OP_JZ, $urandom_range(0, ProgDepth - 1));
        add_instr(OP_PUSHC, pick_value());
        add_instr(OP_STORE, 32'd0);
        add_instr(OP_BINOP, $urandom_range(0, 9));
      end
    endcase
  endtask

  // Hold the sender until every queued transfer is done and answered.
  task automatic wait_drained();
    while (pending_items.size() != 0 || s_axis_tvalid || due_results.size() != 0)
      @(posedge clk_i);
  endtask

  // Record each accepted instruction and what it must produce.
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      due_results.push_back(exec_instr(0, s_axis_tdata[3:0], s_axis_tdata[35:4]));
      n_acc++;
      took <= 1'b1;
    end else begin
      took <= 1'b0;
    end
  end

  // Driver: advance to the next pending item once the current one is taken.
  always @(negedge clk_i) begin
    bit go;
    go = (phase == 1) ? ($urandom_range(0, 99) >= 76) :
         (phase == 3) ? ($urandom_range(0, 99) >= 25) : 1'b1;
    if (rst_ni && (!s_axis_tvalid || took)) begin
      if (pending_items.size() != 0 && go) begin
        s_axis_tdata  <= pending_items.pop_front();
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver back-pressure.
  always @(negedge clk_i) begin
    m_axis_tready <= rst_ni && ((phase == 2) ? ($urandom_range(0, 99) >= 76) :
                                (phase == 3) ? ($urandom_range(0, 99) >= 25) : 1'b1);
  end

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%08h, got 0x%08h", name, want, got);
      n_err++;
    end
  endtask

  // Monitor: compare each result transfer with the oldest prediction.
  always @(posedge clk_i) begin
    step_res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      n_res++;
      if (due_results.size() == 0) begin
        $error("result transfer with no instruction outstanding");
        n_err++;
      end else begin
        want = due_results.pop_front();
        status_seen[want.status]++;
        check_field("next_pc", want.next_pc, m_axis_tdata[7:0]);
        check_field("write_valid", want.wr_valid, m_axis_tuser);
        check_field("write_value", want.wr_value, m_axis_tdata[39:8]);
        check_field("status", want.status, m_axis_tdata[42:40]);
        check_field("stack_count", want.depth, m_axis_tdata[50:43]);
      end
    end
  end

  initial begin
    #2_000_000;
    $display("Timeout waiting for results");
    $display("Some tests failed");
    $finish;
  end

  initial begin
    for (int m = 0; m < 2; m++) begin
      sp[m] = 0;
      pc[m] = '0;
      halted[m] = 1'b0;
      for (int i = 0; i < VarDepth; i++) vmem[m][i] = '0;
    end
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: extremes, every operator and each error path but overflow
    add_instr(OP_BINOP, BO_ADD);             // underflow on empty stack
    add_instr(OP_PUSHC, 32'h8000_0000);
    add_instr(OP_PUSHC, 32'hFFFF_FFFF);
    add_instr(OP_BINOP, BO_DIV);             // most negative over minus one
    add_instr(OP_PUSHC, 32'h7FFF_FFFF);
    add_instr(OP_PUSHC, 32'd0);
    add_instr(OP_BINOP, BO_DIV);             // divide by zero
    add_instr(OP_BINOP, 32'd10);             // operator out of range
    add_instr(OP_BINOP, 32'hFFFF_FFFF);
    for (int b = BO_SUB; b <= BO_GE; b++) begin
      add_instr(OP_DUP, 32'd0);
      add_instr(OP_BINOP, b);
    end
    add_instr(OP_NEG, 32'd0);
    add_instr(OP_WRITE, 32'd0);
    add_instr(4'd15, 32'd0);                 // unknown opcode
    add_instr(4'd11, 32'hFFFF_FFFF);
    add_instr(OP_JZ, 32'd256);               // bad target, not taken or taken
    add_instr(OP_JZ, 32'h8000_0000);
    add_instr(OP_JMP, 32'd255);
    add_instr(OP_JMP, 32'hFFFF_FFFF);
    add_instr(OP_PUSHA, 32'd127);
    add_instr(OP_PUSHC, 32'h7FFF_FFFF);
    add_instr(OP_STORE, 32'd0);
    add_instr(OP_PUSHA, 32'd127);
    add_instr(OP_DEREF, 32'd0);
    add_instr(OP_PUSHA, 32'd128);            // address out of range
    add_instr(OP_DEREF, 32'd0);
    add_instr(OP_PUSHA, 32'h8000_0000);
    add_instr(OP_DEREF, 32'd0);
    add_instr(OP_PUSHC, 32'd0);
    add_instr(OP_JZ, 32'd200);               // taken
    add_instr(OP_PUSHC, 32'd7);
    add_instr(OP_JZ, 32'd3);                 // not taken
    wait_drained();

    // random, a quarter in each idling phase, draining between phases
    for (int ph = 0; ph < 4; ph++) begin
      phase = ph;
      while (n_gen < 30 + (ph + 1) * (NumItems - 30) / 4) gen_sequence();
      wait_drained();
    end

    // stop latches halted; everything after it must answer halted
    phase = 3;
    add_instr(OP_STOP, $urandom);
    add_instr(OP_PUSHC, 32'd1);
    add_instr(OP_JMP, 32'd0);
    add_instr(OP_STOP, 32'd0);
    wait_drained();
    repeat (50) @(posedge clk_i);

    $display("Ran %0d instructions, %0d results; ok %0d, halted %0d, overflow %0d,",
             n_acc, n_res, status_seen[ST_OK], status_seen[ST_HALT], status_seen[ST_OVER]);
    $display("underflow %0d, divide by zero %0d, bad address %0d, bad op/target %0d",
             status_seen[ST_UNDER], status_seen[ST_DIVZ], status_seen[ST_ADDR],
             status_seen[ST_BAD]);
    if (n_err == 0 && due_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
